FILE: src/acl_pkg.sv
// ----------------------------------------------------------------------------
// acl_pkg
// shared types and codes for the ipv4 access list matcher
// ----------------------------------------------------------------------------
package acl_pkg;
	typedef enum logic [2:0] {
		OP_ADD_EXACT = 3'd0,
		OP_ADD_RANGE = 3'd1,
		OP_ADD_MASK  = 3'd2,
		OP_LOOKUP    = 3'd3,
		OP_CLEAR     = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_RANGE = 2'd1,
		KIND_EXACT = 2'd2,
		KIND_MASK  = 2'd3
	} kind_t;

	// per-cell summary flags for a request
	typedef struct packed {
		logic below;   // stored key/high less than the probe
		logic equal;   // stored low equals the probe
		logic hit;     // probe inside stored entry
	} cell_flags_t;
endpackage

FILE: src/acl_cell.sv
// ----------------------------------------------------------------------------
// acl_cell
// one storage cell of a sorted chain; holds a low/high pair and can take
// the contents of its left neighbor (insert shift) or right neighbor (delete)
// ----------------------------------------------------------------------------
module acl_cell (
	input  logic                clk,
	input  logic                load,
	input  logic [31:0]         load_lo,
	input  logic [31:0]         load_hi,
	input  logic [31:0]         probe,
	output logic [31:0]         lo,
	output logic [31:0]         hi,
	output acl_pkg::cell_flags_t flags
);
	import acl_pkg::*;

	logic [31:0] lo_q;
	logic [31:0] hi_q;

	always_ff @(posedge clk) begin
		if (load) begin
			lo_q <= load_lo;
			hi_q <= load_hi;
		end
	end

	assign lo = lo_q;
	assign hi = hi_q;
	assign flags.below = hi_q < probe;
	assign flags.equal = lo_q == probe;
	assign flags.hit   = (lo_q <= probe) && (probe <= hi_q);
endmodule

FILE: src/acl_chain.sv
// ----------------------------------------------------------------------------
// acl_chain
// sorted row of cells with insert-shift and merge-collapse operations
// ----------------------------------------------------------------------------
module acl_chain #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	// insert at pos (shift right), or write pos and, when rem is set, drop cell pos+1
	input  logic                     ins,
	input  logic                     mrg,
	input  logic [$clog2(DEPTH):0]   pos,
	input  logic [$clog2(DEPTH):0]   rem,
	input  logic [31:0]              new_lo,
	input  logic [31:0]              new_hi,
	input  logic [31:0]              probe,
	output logic [$clog2(DEPTH):0]   used,
	output logic [$clog2(DEPTH):0]   first_ge,   // count of cells with hi < probe
	output logic                     any_hit,
	output logic                     any_eq,
	output logic [31:0]              cell_lo [DEPTH],
	output logic [31:0]              cell_hi [DEPTH]
);
	import acl_pkg::*;
	localparam int CW = $clog2(DEPTH) + 1;

	logic [CW-1:0]    used_q;
	cell_flags_t      fl [DEPTH];
	logic             ld [DEPTH];
	logic [31:0]      ldl [DEPTH];
	logic [31:0]      ldh [DEPTH];
	logic [DEPTH-1:0] bl;
	logic [DEPTH-1:0] bl_edge;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic [CW-1:0] idx;
			assign idx = CW'(g);
			always_comb begin
				ld[g]  = 1'b0;
				ldl[g] = new_lo;
				ldh[g] = new_hi;
				if (ins) begin
					if (idx == pos) begin
						ld[g] = 1'b1;
					end else if (idx > pos && idx <= used_q) begin
						ld[g] = 1'b1;
						if (g > 0) begin
							ldl[g] = cell_lo[(g > 0) ? g - 1 : 0];
							ldh[g] = cell_hi[(g > 0) ? g - 1 : 0];
						end
					end
				end else if (mrg) begin
					if (idx == pos) begin
						ld[g] = 1'b1;
					end else if (idx > pos && rem != '0) begin
						ld[g] = 1'b1;
						ldl[g] = cell_lo[(g + 1 < DEPTH) ? g + 1 : g];
						ldh[g] = cell_hi[(g + 1 < DEPTH) ? g + 1 : g];
					end
				end
			end
			acl_cell u_cell (
				.clk(clk), .load(ld[g]), .load_lo(ldl[g]), .load_hi(ldh[g]),
				.probe(probe), .lo(cell_lo[g]), .hi(cell_hi[g]), .flags(fl[g])
			);
		end
	endgenerate

	// below flags form a prefix of the sorted row; encode its end
	always_comb begin
		any_hit = 1'b0;
		any_eq  = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			bl[i] = (CW'(i) < used_q) && fl[i].below;
			if (CW'(i) < used_q) begin
				any_hit = any_hit | fl[i].hit;
				any_eq  = any_eq | fl[i].equal;
			end
		end
	end

	assign bl_edge = bl & ~(bl >> 1);

	always_comb begin
		first_ge = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (bl_edge[i]) first_ge = first_ge | CW'(i + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (clear) begin
			used_q <= '0;
		end else if (ins) begin
			used_q <= used_q + 1'b1;
		end else if (mrg) begin
			used_q <= used_q - rem;
		end
	end

	assign used = used_q;
endmodule

FILE: src/ipv4_access_list_matcher.sv
// ----------------------------------------------------------------------------
// ipv4_access_list_matcher
// ipv4 block list with exact, range and prefix stores held in cell rows
// ----------------------------------------------------------------------------
// One request at a time: start is taken when busy is low, and the result
// appears with done high for one cycle. A request compares and updates all
// cells of a row together in the eval state, then done is raised in the done
// state and busy stays high through it, so a new request is taken only after
// the last one is through. A range that overlaps n stored ranges goes through
// the merge state, collapsing the row one removed range per cycle (at most
// RANGE_DEPTH). Results cannot be held off, so done is the only indication.
module ipv4_access_list_matcher #(
	parameter int EXACT_DEPTH  = 256,
	parameter int RANGE_DEPTH  = 64,
	parameter int PREFIX_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [31:0] addr_a,
	input  logic [31:0] addr_b,
	output logic        done,
	output logic        hit,
	output logic [1:0]  match_kind,
	output logic        status
);
	import acl_pkg::*;
	localparam int EW = $clog2(EXACT_DEPTH) + 1;
	localparam int RW = $clog2(RANGE_DEPTH) + 1;
	localparam int PW = $clog2(PREFIX_DEPTH) + 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EVAL  = 4'b0010,
		ST_MERGE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t      state_q;
	logic [2:0]  op_q;
	logic [31:0] a_q, b_q, lo_q, hi_q, probe;
	logic        hit_q, stat_q;
	logic [1:0]  kind_q;

	// exact row
	logic          e_ins;
	logic [EW-1:0] e_used, e_ge;
	logic          e_hit, e_eq;
	logic [31:0]   e_lo [EXACT_DEPTH];
	logic [31:0]   e_hi [EXACT_DEPTH];
	// range row
	logic          r_ins, r_mrg;
	logic [RW-1:0] r_used, r_ge, r_pos, r_rem, r_end;
	logic          r_hit, r_eq;
	logic [31:0]   r_lo [RANGE_DEPTH];
	logic [31:0]   r_hi [RANGE_DEPTH];
	logic [31:0]   m_lo, m_hi;
	logic [RANGE_DEPTH-1:0] r_le;
	logic [RANGE_DEPTH-1:0] r_le_edge;
	logic [RW-2:0] r_first_idx, r_last_idx;
	logic [31:0]   r_new_lo, r_new_hi;
	logic [RW-1:0] r_rem_q, r_pos_q;
	logic [31:0]   m_lo_q, m_hi_q;

	logic          clr;
	logic          deg;
	logic [31:0]   ex_key;

	// prefix row (unsorted, append)
	logic [31:0]   p_base_q [PREFIX_DEPTH];
	logic [31:0]   p_mask_q [PREFIX_DEPTH];
	logic [PW-1:0] p_used_q;
	logic          p_hit, p_covered, p_rep;
	logic [PREFIX_DEPTH-1:0] p_act_v, p_cov_v, p_first;
	logic [31:0]   nbase;

	logic [31:0] ra, rb;

	assign deg    = (op_q == OP_ADD_RANGE) && (lo_q == hi_q);
	assign ex_key = (op_q == OP_ADD_RANGE) ? lo_q : a_q;
	assign probe  = (op_q == OP_ADD_RANGE && !deg) ? lo_q : ex_key;
	assign clr    = (state_q == ST_EVAL) && (op_q == OP_CLEAR);

	// exact row keeps key in both lo and hi so below == key < probe
	assign e_ins = (state_q == ST_EVAL) && (op_q == OP_ADD_EXACT || deg)
		&& !e_eq && (e_used < EW'(EXACT_DEPTH));

	acl_chain #(.DEPTH(EXACT_DEPTH)) u_exact (
		.clk(clk), .arst_n(arst_n), .clear(clr), .ins(e_ins), .mrg(1'b0),
		.pos(e_ge), .rem('0), .new_lo(ex_key), .new_hi(ex_key), .probe(probe),
		.used(e_used), .first_ge(e_ge), .any_hit(e_hit), .any_eq(e_eq),
		.cell_lo(e_lo), .cell_hi(e_hi)
	);

	// overlap span ends where stored lo exceeds hi_q (a prefix of the row)
	always_comb begin
		for (int i = 0; i < RANGE_DEPTH; i++) begin
			r_le[i] = (RW'(i) < r_used) && (r_lo[i] <= hi_q);
		end
	end

	assign r_le_edge = r_le & ~(r_le >> 1);

	always_comb begin
		r_end = '0;
		for (int i = 0; i < RANGE_DEPTH; i++) begin
			if (r_le_edge[i]) r_end = r_end | RW'(i + 1);
		end
	end

	// rows are sorted and disjoint: first cell holds the low end, last the high
	assign r_first_idx = r_ge[RW-2:0];
	assign r_last_idx  = r_end[RW-2:0] - 1'b1;
	assign m_lo = (r_lo[r_first_idx] < lo_q) ? r_lo[r_first_idx] : lo_q;
	assign m_hi = (r_hi[r_last_idx] > hi_q) ? r_hi[r_last_idx] : hi_q;

	assign r_pos    = (state_q == ST_MERGE) ? r_pos_q : r_ge;
	assign r_rem    = RW'(r_rem_q > RW'(1));
	assign r_new_lo = (state_q == ST_MERGE) ? m_lo_q : lo_q;
	assign r_new_hi = (state_q == ST_MERGE) ? m_hi_q : hi_q;
	assign r_ins = (state_q == ST_EVAL) && (op_q == OP_ADD_RANGE) && !deg
		&& (r_end == r_ge) && (r_used < RW'(RANGE_DEPTH));
	assign r_mrg = (state_q == ST_MERGE);

	acl_chain #(.DEPTH(RANGE_DEPTH)) u_range (
		.clk(clk), .arst_n(arst_n), .clear(clr), .ins(r_ins), .mrg(r_mrg),
		.pos(r_pos), .rem(r_rem), .new_lo(r_new_lo), .new_hi(r_new_hi),
		.probe(probe), .used(r_used), .first_ge(r_ge), .any_hit(r_hit),
		.any_eq(r_eq), .cell_lo(r_lo), .cell_hi(r_hi)
	);

	assign nbase = a_q & b_q;

	always_comb begin
		p_hit   = 1'b0;
		p_act_v = '0;
		p_cov_v = '0;
		for (int i = 0; i < PREFIX_DEPTH; i++) begin
			if (PW'(i) < p_used_q) begin
				if ((a_q & p_mask_q[i]) == p_base_q[i]) p_hit = 1'b1;
				if (p_base_q[i] == nbase) begin
					if ((b_q & p_mask_q[i]) == p_mask_q[i]) begin
						p_act_v[i] = 1'b1;
						p_cov_v[i] = 1'b1;
					end else if ((b_q & p_mask_q[i]) == b_q) begin
						p_act_v[i] = 1'b1;
					end
				end
			end
		end
	end

	// first entry with an equal base and nested masks decides
	assign p_first   = p_act_v & (~p_act_v + 1'b1);
	assign p_covered = |(p_first & p_cov_v);
	assign p_rep     = (|p_act_v) && !p_covered;

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL && op_q == OP_ADD_MASK && !p_covered) begin
			for (int i = 0; i < PREFIX_DEPTH; i++) begin
				if (p_rep) begin
					if (p_first[i]) p_mask_q[i] <= b_q;
				end else if (PW'(i) == p_used_q) begin
					p_base_q[i] <= nbase;
					p_mask_q[i] <= b_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_used_q <= '0;
		end else if (clr) begin
			p_used_q <= '0;
		end else if (state_q == ST_EVAL && op_q == OP_ADD_MASK && !p_covered && !p_rep
			&& p_used_q < PW'(PREFIX_DEPTH)) begin
			p_used_q <= p_used_q + 1'b1;
		end
	end

	assign ra = (addr_a < addr_b) ? addr_a : addr_b;
	assign rb = (addr_a < addr_b) ? addr_b : addr_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (start) state_q <= ST_EVAL;
				ST_EVAL:  state_q <= (op_q == OP_ADD_RANGE && !deg && r_end != r_ge)
					? ST_MERGE : ST_DONE;
				ST_MERGE: if (r_rem_q <= RW'(1)) state_q <= ST_DONE;
				ST_DONE:  state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q <= opcode;
			a_q  <= addr_a;
			b_q  <= addr_b;
			lo_q <= ra;
			hi_q <= rb;
		end
		if (state_q == ST_MERGE) begin
			r_rem_q <= r_rem_q - 1'b1;
		end
		if (state_q == ST_EVAL) begin
			r_pos_q <= r_ge;
			r_rem_q <= r_end - r_ge;
			m_lo_q  <= m_lo;
			m_hi_q  <= m_hi;
			hit_q   <= 1'b0;
			kind_q  <= KIND_NONE;
			stat_q  <= 1'b0;
			unique case (op_q)
				OP_ADD_EXACT: stat_q <= !e_eq && (e_used >= EW'(EXACT_DEPTH));
				OP_ADD_RANGE: stat_q <= deg ? (!e_eq && e_used >= EW'(EXACT_DEPTH))
					: (r_end == r_ge && r_used >= RW'(RANGE_DEPTH));
				OP_ADD_MASK:  stat_q <= !p_covered && !p_rep
					&& p_used_q >= PW'(PREFIX_DEPTH);
				OP_LOOKUP: begin
					hit_q  <= r_hit | e_eq | p_hit;
					kind_q <= r_hit ? KIND_RANGE : e_eq ? KIND_EXACT
						: p_hit ? KIND_MASK : KIND_NONE;
				end
				default: ;
			endcase
		end
	end

	assign busy       = state_q != ST_IDLE;
	assign done       = state_q == ST_DONE;
	assign hit        = hit_q;
	assign match_kind = kind_q;
	assign status     = stat_q;

	logic unused_ok;
	assign unused_ok = ^{r_eq, e_hit, e_lo[0], e_hi[0]};

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_hit_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hit == (match_kind != KIND_NONE))) else $error("hit/kind");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy");
endmodule
